// ===== src/mfr_pkg.sv =====
// shared types, codes and the crc byte update for the multidrop frame receiver
package mfr_pkg;

   localparam logic [7:0]  START_BYTE = 8'hFF;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_HEADER = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRC    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      REG_NODE_ADDR  = 3'd0,
      REG_BCAST_ADDR = 3'd1,
      REG_BATCH_MASK = 3'd2,
      REG_RESP_MASK  = 3'd3,
      REG_ADDR_CMD   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0] node_address;
      logic [7:0] all_nodes_address;
      logic [7:0] batch_flag_mask;
      logic [7:0] response_flag_mask;
      logic [7:0] addressing_command;
   } cfg_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic [7:0] data_index;
      logic       frame_done;
      logic       crc_error;
      logic       to_me;
      logic [7:0] frame_command;
      logic       batch_mode;
      logic       response_message;
      logic       addressing_frame;
      logic [7:0] slice_length;
   } rsp_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== src/mfr_csr.sv =====
// configuration register file on the apb-style port
module mfr_csr
   import mfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_NODE_ADDR:  cfg_in.node_address       = csr_pwdata[7:0];
            REG_BCAST_ADDR: cfg_in.all_nodes_address  = csr_pwdata[7:0];
            REG_BATCH_MASK: cfg_in.batch_flag_mask    = csr_pwdata[7:0];
            REG_RESP_MASK:  cfg_in.response_flag_mask = csr_pwdata[7:0];
            REG_ADDR_CMD:   cfg_in.addressing_command = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_NODE_ADDR:  csr_prdata = {24'h0, cfg_ff.node_address};
         REG_BCAST_ADDR: csr_prdata = {24'h0, cfg_ff.all_nodes_address};
         REG_BATCH_MASK: csr_prdata = {24'h0, cfg_ff.batch_flag_mask};
         REG_RESP_MASK:  csr_prdata = {24'h0, cfg_ff.response_flag_mask};
         REG_ADDR_CMD:   csr_prdata = {24'h0, cfg_ff.addressing_command};
         default:        csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_address       <= 8'h00;
         cfg_ff.all_nodes_address  <= 8'h00;
         cfg_ff.batch_flag_mask    <= 8'h01;
         cfg_ff.response_flag_mask <= 8'h02;
         cfg_ff.addressing_command <= 8'h00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/mfr_parser.sv =====
// frame parser state, crc and slice tracking, one byte per accepted beat
module mfr_parser
   import mfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output rsp_type    rsp
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic [7:0]  flag_ff, flag_in;
   logic [7:0]  target_ff, target_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  node_count_ff, node_count_in;
   logic [7:0]  per_node_ff, per_node_in;
   logic [15:0] total_len_ff, total_len_in;
   logic [15:0] slice_off_ff, slice_off_in;
   logic [15:0] total_idx_ff, total_idx_in;
   logic [7:0]  slice_idx_ff, slice_idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        crc_seen_ff, crc_seen_in;

   logic [15:0] crc_next;
   logic [7:0]  node_minus_one;
   logic        hdr_end;
   logic        addr_hit;
   logic        data_end;
   logic        slice_hit;
   logic        crc_match;
   logic [7:0]  crc_expect;
   logic        is_start;

   assign crc_next       = crc_byte(crc_ff, rx_byte);
   assign node_minus_one = cfg.node_address - 8'd1;
   assign addr_hit       = (command_ff == cfg.addressing_command);
   assign slice_hit      = (total_idx_ff >= slice_off_ff) && (slice_idx_ff < per_node_ff);
   assign data_end       = ((total_idx_ff + 16'd1) >= total_len_ff);
   assign crc_expect     = crc_seen_ff ? crc_ff[7:0] : crc_ff[15:8];
   assign crc_match      = (crc_expect == rx_byte);
   assign is_start       = (rx_byte == START_BYTE);
   assign hdr_end        = (phase_ff == PH_HEADER) && (hdr_pos_ff >= 3'd4 ||
                           (hdr_pos_ff == 3'd3 && (flag_ff & cfg.batch_flag_mask) == 8'h00));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE:  phase_in = is_start ? PH_START : PH_IDLE;
         PH_START: phase_in = is_start ? PH_HEADER : PH_IDLE;
         PH_HEADER: begin
            if (hdr_end) begin
               if (addr_hit)                  phase_in = PH_IDLE;
               else if (per_node_in == 8'h00) phase_in = PH_CRC;
               else                           phase_in = PH_DATA;
            end
         end
         PH_DATA:  phase_in = data_end ? PH_CRC : PH_DATA;
         PH_CRC:   phase_in = (!crc_match || crc_seen_ff) ? PH_IDLE : PH_CRC;
         default:  phase_in = PH_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      hdr_pos_in    = hdr_pos_ff;
      flag_in       = flag_ff;
      target_in     = target_ff;
      command_in    = command_ff;
      node_count_in = node_count_ff;
      per_node_in   = per_node_ff;
      total_len_in  = total_len_ff;
      slice_off_in  = slice_off_ff;
      total_idx_in  = total_idx_ff;
      slice_idx_in  = slice_idx_ff;
      crc_in        = crc_ff;
      crc_seen_in   = crc_seen_ff;
      case (phase_ff)
         PH_START: begin
            if (is_start) begin
               flag_in      = 8'h00;
               per_node_in  = 8'h00;
               target_in    = 8'h00;
               slice_idx_in = 8'h00;
               total_len_in = 16'h0000;
               total_idx_in = 16'h0000;
               slice_off_in = 16'h0000;
               crc_in       = CRC_INIT;
               crc_seen_in  = 1'b0;
               hdr_pos_in   = 3'd0;
            end
         end
         PH_HEADER: begin
            crc_in = crc_next;
            case (hdr_pos_ff)
               3'd0: begin
                  flag_in    = rx_byte;
                  hdr_pos_in = 3'd1;
               end
               3'd1: begin
                  target_in  = rx_byte;
                  hdr_pos_in = 3'd2;
               end
               3'd2: begin
                  command_in = rx_byte;
                  hdr_pos_in = 3'd3;
               end
               3'd3: begin
                  hdr_pos_in = 3'd4;
                  if ((flag_ff & cfg.batch_flag_mask) != 8'h00) begin
                     node_count_in = rx_byte;
                  end else begin
                     per_node_in  = rx_byte;
                     total_len_in = {8'h00, rx_byte};
                     slice_off_in = 16'h0000;
                  end
               end
               default: begin
                  hdr_pos_in = 3'd5;
                  if (cfg.node_address != 8'h00) begin
                     per_node_in  = rx_byte;
                     total_len_in = {8'h00, rx_byte} * {8'h00, node_count_ff};
                     slice_off_in = {8'h00, node_minus_one} * {8'h00, rx_byte};
                  end else begin
                     per_node_in = 8'h00;
                  end
               end
            endcase
            if (hdr_end && !addr_hit && per_node_in == 8'h00) begin
               crc_seen_in = 1'b0;
            end
         end
         PH_DATA: begin
            crc_in       = crc_next;
            total_idx_in = total_idx_ff + 16'd1;
            if (slice_hit) begin
               slice_idx_in = slice_idx_ff + 8'd1;
            end
            if (data_end) begin
               crc_seen_in = 1'b0;
            end
         end
         PH_CRC: begin
            crc_seen_in = crc_match && !crc_seen_ff;
         end
         default: ;
      endcase
   end

   // result of this beat, from the current state; the header fields come from the updated values
   always_comb begin
      rsp.data_valid       = (phase_ff == PH_DATA) && slice_hit;
      rsp.data_byte        = rsp.data_valid ? rx_byte : 8'h00;
      rsp.data_index       = rsp.data_valid ? slice_idx_ff : 8'h00;
      rsp.frame_done       = (phase_ff == PH_CRC) && crc_match && crc_seen_ff;
      rsp.crc_error        = (phase_ff == PH_CRC) && !crc_match;
      rsp.to_me            = (target_in == cfg.node_address) ||
                             (target_in == cfg.all_nodes_address);
      rsp.frame_command    = command_in;
      rsp.batch_mode       = (flag_in & cfg.batch_flag_mask) != 8'h00;
      rsp.response_message = (flag_in & cfg.response_flag_mask) != 8'h00;
      rsp.addressing_frame = hdr_end && addr_hit;
      rsp.slice_length     = per_node_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_pos_ff    <= 3'd0;
         flag_ff       <= 8'h00;
         target_ff     <= 8'h00;
         command_ff    <= 8'h00;
         node_count_ff <= 8'h00;
         per_node_ff   <= 8'h00;
         total_len_ff  <= 16'h0000;
         slice_off_ff  <= 16'h0000;
         total_idx_ff  <= 16'h0000;
         slice_idx_ff  <= 8'h00;
         crc_ff        <= CRC_INIT;
         crc_seen_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         flag_ff       <= flag_in;
         target_ff     <= target_in;
         command_ff    <= command_in;
         node_count_ff <= node_count_in;
         per_node_ff   <= per_node_in;
         total_len_ff  <= total_len_in;
         slice_off_ff  <= slice_off_in;
         total_idx_ff  <= total_idx_in;
         slice_idx_ff  <= slice_idx_in;
         crc_ff        <= crc_in;
         crc_seen_ff   <= crc_seen_in;
      end
   end

endmodule

// ===== src/multidrop_frame_receiver.sv =====
// multidrop frame receiver top level: csr block, frame parser and result register
// a result beat is valid the cycle after its byte is accepted
// throughput: one byte per cycle while the result channel is not stalled; the parser state, crc and slice math
// are combinational between the parser registers and the result register
// reset (synchronous, active high) puts the parser in idle hunting for 0xff, crc at all ones,
// and the registers at their defaults; no clearing pass
module multidrop_frame_receiver
   import mfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_data_index,
   output logic        rsp_frame_done,
   output logic        rsp_crc_error,
   output logic        rsp_to_me,
   output logic [7:0]  rsp_frame_command,
   output logic        rsp_batch_mode,
   output logic        rsp_response_message,
   output logic        rsp_addressing_frame,
   output logic [7:0]  rsp_slice_length,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_accept;

   mfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the result register frees up in the same cycle its beat is taken
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   mfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   // every accepted byte yields exactly one result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data_valid       = rsp_ff.data_valid;
   assign rsp_data_byte        = rsp_ff.data_byte;
   assign rsp_data_index       = rsp_ff.data_index;
   assign rsp_frame_done       = rsp_ff.frame_done;
   assign rsp_crc_error        = rsp_ff.crc_error;
   assign rsp_to_me            = rsp_ff.to_me;
   assign rsp_frame_command    = rsp_ff.frame_command;
   assign rsp_batch_mode       = rsp_ff.batch_mode;
   assign rsp_response_message = rsp_ff.response_message;
   assign rsp_addressing_frame = rsp_ff.addressing_frame;
   assign rsp_slice_length     = rsp_ff.slice_length;

   // an accepted byte always shows up as a beat on the next cycle
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted byte produced no result beat");

   // frame end outcomes are exclusive
   a_done_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.frame_done && rsp_ff.crc_error))
      else $error("frame done and crc error in one beat");

   // a payload beat never coincides with a frame end or header end
   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.data_valid) |->
         !(rsp_ff.frame_done || rsp_ff.crc_error || rsp_ff.addressing_frame))
      else $error("payload beat overlaps frame event");

   // slice position stays inside the slice
   a_index_in_slice: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.data_valid) |-> (rsp_ff.data_index < rsp_ff.slice_length))
      else $error("payload index beyond slice length");

endmodule
